@@ hw/rtl/iwcts_pkg.sv @@
// Shared types, widths and codes for the in-flight writer closed timestamp table.
package iwcts_pkg;

  localparam int ID_W = 32;
  localparam int TS_W = 62;
  localparam int OP_W = 2;
  localparam int ST_W = 2;
  localparam int TABLE_ENTRIES_DEF = 16;
  // Slot numbers travel in the request struct at the widest supported size.
  localparam int IDX_MAX_W = 8;

  localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

  localparam logic [OP_W-1:0] OP_REGISTER  = 2'd0;
  localparam logic [OP_W-1:0] OP_ADVERTISE = 2'd1;
  localparam logic [OP_W-1:0] OP_DROP      = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic                 wr_en;
    logic                 set_vld;
    logic                 clr_vld;
    logic [IDX_MAX_W-1:0] wr_addr;
    logic [ID_W-1:0]      wr_txn;
    logic [TS_W-1:0]      wr_bound;
  } store_req_t;

  typedef struct packed {
    logic            vld;
    logic [ID_W-1:0] txn;
    logic [TS_W-1:0] bound;
  } store_rd_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [TS_W-1:0] result_ts;
  } result_t;

endpackage

@@ hw/rtl/inflight_writer_closed_ts_table.sv @@
// Top level of the in-flight writer table with closed timestamp advertisement.
//
// Input channel: in_valid/in_stall carry one beat of operation, txn_id and
// timestamp. Operation 0 registers a writer, 1 tries to advertise a snapshot,
// 2 drops a resolved writer. Output channel: out_valid/out_stall carry one
// beat of status and result_ts for every input beat, in order.
// Each beat is handled by a sequencer that reads one table entry per cycle
// from the table memory and checks it in a single compare unit. A beat passes
// through the scan of every entry, a drain of the read pipeline and the table
// update before its result reaches the result register. in_stall is high
// during that time, so the next beat is accepted only once the result has
// been handed over.
// The result register decouples the sides: a new beat is accepted while a
// finished result waits, and when out_stall holds, the next result waits in
// the sequencer with the table unchanged until the register frees up.
// Synchronous reset empties the table and clears the advertised timestamp;
// the block is ready in the first cycle after reset.
module inflight_writer_closed_ts_table #(
  parameter int TABLE_ENTRIES = iwcts_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [iwcts_pkg::OP_W-1:0] operation,
  input  logic [iwcts_pkg::ID_W-1:0] txn_id,
  input  logic [iwcts_pkg::TS_W-1:0] timestamp,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [iwcts_pkg::ST_W-1:0] status,
  output logic [iwcts_pkg::TS_W-1:0] result_ts
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  logic [IDX_W-1:0]      rd_addr;
  iwcts_pkg::store_req_t req;
  iwcts_pkg::store_rd_t  rd;
  logic                  res_valid;
  logic                  res_take;
  iwcts_pkg::result_t    res;

  iwcts_store #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .req     (req),
    .rd      (rd)
  );

  iwcts_scan #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .txn_id    (txn_id),
    .timestamp (timestamp),
    .rd_addr   (rd_addr),
    .req       (req),
    .rd        (rd),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      status    <= res.status;
      result_ts <= res.result_ts;
    end
  end

  // An accepted beat keeps the input side busy while the table is scanned.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again right after a beat");

  // A result handed over by the sequencer always lands in the output register.
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_take |=> out_valid)
    else $error("finished result was lost");

  // Only defined status codes leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == iwcts_pkg::ST_OK || status == iwcts_pkg::ST_REFUSED ||
                   status == iwcts_pkg::ST_FULL))
    else $error("undefined status code on output");

endmodule

@@ hw/rtl/iwcts_store.sv @@
// Writer table storage: id and bound memories with registered read, valid bits in flops.
module iwcts_store #(
  parameter int TABLE_ENTRIES = iwcts_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]  rd_addr,
  input  iwcts_pkg::store_req_t             req,
  output iwcts_pkg::store_rd_t              rd
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  logic [iwcts_pkg::ID_W-1:0] txn_mem   [TABLE_ENTRIES];
  logic [iwcts_pkg::TS_W-1:0] bound_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]   vld;

  logic [IDX_W-1:0]           wa;
  logic                       rd_vld;
  logic [iwcts_pkg::ID_W-1:0] rd_txn;
  logic [iwcts_pkg::TS_W-1:0] rd_bound;

  assign wa = req.wr_addr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      txn_mem[wa]   <= req.wr_txn;
      bound_mem[wa] <= req.wr_bound;
    end
    rd_txn   <= txn_mem[rd_addr];
    rd_bound <= bound_mem[rd_addr];
    rd_vld   <= vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.set_vld) begin
      vld[wa] <= 1'b1;
    end else if (req.clr_vld) begin
      vld[wa] <= 1'b0;
    end
  end

  assign rd = '{vld: rd_vld, txn: rd_txn, bound: rd_bound};

endmodule

@@ hw/rtl/iwcts_scan.sv @@
// Sequencer that scans the table one entry per cycle through a shared compare unit.
module iwcts_scan #(
  parameter int TABLE_ENTRIES = iwcts_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [iwcts_pkg::OP_W-1:0]        operation,
  input  logic [iwcts_pkg::ID_W-1:0]        txn_id,
  input  logic [iwcts_pkg::TS_W-1:0]        timestamp,
  output logic [$clog2(TABLE_ENTRIES)-1:0]  rd_addr,
  output iwcts_pkg::store_req_t             req,
  input  iwcts_pkg::store_rd_t              rd,
  output logic                              res_valid,
  output iwcts_pkg::result_t                res,
  input  logic                              res_take
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]                 state;
  logic [IDX_W-1:0]           cnt;
  logic                       rd_pend;
  logic [IDX_W-1:0]           rd_idx;
  logic [iwcts_pkg::OP_W-1:0] op_r;
  logic [iwcts_pkg::ID_W-1:0] id_r;
  logic [iwcts_pkg::TS_W-1:0] ts_r;
  logic [iwcts_pkg::TS_W-1:0] eff_r;
  logic [iwcts_pkg::TS_W-1:0] adv;
  logic [iwcts_pkg::TS_W-1:0] adv_next;
  logic                       hit;
  logic [IDX_W-1:0]           hit_slot;
  logic [iwcts_pkg::TS_W-1:0] hit_bound;
  logic                       free_found;
  logic [IDX_W-1:0]           free_slot;
  logic                       refuse;

  logic                       accept;
  logic                       fin_go;
  logic                       match;
  logic                       empty;
  logic                       low;
  logic [iwcts_pkg::TS_W-1:0] floor_ts;
  logic [iwcts_pkg::TS_W-1:0] eff;
  iwcts_pkg::store_req_t      req_raw;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && (state == S_IDLE);
  assign res_valid = (state == S_FINISH);
  assign fin_go    = res_valid && res_take;
  assign rd_addr   = cnt;

  // The new bound sits above the last advertised timestamp unless that is already TS_MAX.
  assign floor_ts = (adv == iwcts_pkg::TS_MAX) ? iwcts_pkg::TS_MAX
                                                : adv + iwcts_pkg::TS_W'(1);
  assign eff      = (timestamp > floor_ts) ? timestamp : floor_ts;

  // Shared compare unit, fed by the entry read in the previous cycle.
  assign match = rd_pend && rd.vld && (rd.txn == id_r);
  assign empty = rd_pend && !rd.vld;
  assign low   = rd_pend && rd.vld && (rd.bound <= ts_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      rd_pend <= 1'b0;
      adv     <= '0;
    end else begin
      rd_pend <= (state == S_SCAN);
      adv     <= adv_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SCAN;
            cnt   <= '0;
          end
        end
        S_SCAN: begin
          if (cnt == LAST_IDX) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        S_DRAIN: state <= S_FINISH;
        S_FINISH: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    if (accept) begin
      op_r       <= operation;
      id_r       <= txn_id;
      ts_r       <= timestamp;
      eff_r      <= eff;
      hit        <= 1'b0;
      free_found <= 1'b0;
      refuse     <= 1'b0;
    end else begin
      if (match && !hit) begin
        hit       <= 1'b1;
        hit_slot  <= rd_idx;
        hit_bound <= rd.bound;
      end
      if (empty && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= rd_idx;
      end
      if (low) begin
        refuse <= 1'b1;
      end
    end
  end

  always_comb begin
    req_raw  = '0;
    res      = '{status: iwcts_pkg::ST_OK, result_ts: adv};
    adv_next = adv;
    unique case (op_r)
      iwcts_pkg::OP_REGISTER: begin
        res.result_ts = eff_r;
        if (hit) begin
          if (eff_r > hit_bound) begin
            req_raw.wr_en    = 1'b1;
            req_raw.wr_addr  = iwcts_pkg::IDX_MAX_W'(hit_slot);
            req_raw.wr_txn   = id_r;
            req_raw.wr_bound = eff_r;
          end else begin
            res.result_ts = hit_bound;
          end
        end else if (free_found) begin
          req_raw.wr_en    = 1'b1;
          req_raw.set_vld  = 1'b1;
          req_raw.wr_addr  = iwcts_pkg::IDX_MAX_W'(free_slot);
          req_raw.wr_txn   = id_r;
          req_raw.wr_bound = eff_r;
        end else begin
          res.status = iwcts_pkg::ST_FULL;
        end
      end
      iwcts_pkg::OP_ADVERTISE: begin
        if (refuse) begin
          res.status = iwcts_pkg::ST_REFUSED;
        end else if (ts_r > adv) begin
          adv_next = ts_r;
        end
        res.result_ts = adv_next;
      end
      iwcts_pkg::OP_DROP: begin
        if (hit) begin
          req_raw.clr_vld = 1'b1;
          req_raw.wr_addr = iwcts_pkg::IDX_MAX_W'(hit_slot);
        end
      end
      default: ;
    endcase
    // State only changes in the cycle the result is handed over.
    if (!fin_go) begin
      adv_next = adv;
    end
    req         = req_raw;
    req.wr_en   = req_raw.wr_en && fin_go;
    req.set_vld = req_raw.set_vld && fin_go;
    req.clr_vld = req_raw.clr_vld && fin_go;
  end

endmodule

@@ tb/inflight_writer_closed_ts_table_test.sv @@
// Self-checking testbench for the in-flight writer closed timestamp table.
module inflight_writer_closed_ts_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES = iwcts_pkg::TABLE_ENTRIES_DEF;
  localparam int LATENCY = TABLE_ENTRIES + 3;
  localparam logic [iwcts_pkg::OP_W-1:0] OP_NONE = 2'd3;
  localparam int RANDOM_BEATS = 1000;
  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD = 400;
  localparam int ID_POOL = 24;
  localparam int REPORT_LIMIT = 10;

  typedef logic [iwcts_pkg::TS_W-1:0] ts_t;
  typedef logic [iwcts_pkg::ID_W-1:0] id_t;
  typedef logic [iwcts_pkg::OP_W-1:0] op_t;

  // Mirrors the writer table and the closed timestamp, and queues the result
  // that every accepted request beat must produce.
  class closed_ts_scoreboard;
    bit                 slot_used[TABLE_ENTRIES];
    id_t                slot_txn[TABLE_ENTRIES];
    ts_t                slot_bound[TABLE_ENTRIES];
    ts_t                closed_ts;
    iwcts_pkg::result_t expected_q[$];
    int                 mismatches;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      closed_ts = '0;
      mismatches = 0;
    endfunction

    function int find_writer(id_t id);
      foreach (slot_used[i])
        if (slot_used[i] && slot_txn[i] == id) return i;
      return -1;
    endfunction

    function void note_beat(op_t op, id_t id, ts_t ts);
      iwcts_pkg::result_t r;
      ts_t                floor_ts;
      int                 s;
      bit                 refused;
      r.status = iwcts_pkg::ST_OK;
      r.result_ts = closed_ts;
      case (op)
        iwcts_pkg::OP_REGISTER: begin
          floor_ts = (closed_ts == iwcts_pkg::TS_MAX) ? iwcts_pkg::TS_MAX : closed_ts + 1'b1;
          r.result_ts = (ts > floor_ts) ? ts : floor_ts;
          s = find_writer(id);
          if (s >= 0) begin
            if (r.result_ts > slot_bound[s]) slot_bound[s] = r.result_ts;
            else r.result_ts = slot_bound[s];
          end else begin
            // A new writer takes the lowest free slot.
            for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
              if (!slot_used[i]) s = i;
            if (s >= 0) begin
              slot_used[s] = 1'b1;
              slot_txn[s] = id;
              slot_bound[s] = r.result_ts;
            end else begin
              r.status = iwcts_pkg::ST_FULL;
            end
          end
        end
        iwcts_pkg::OP_ADVERTISE: begin
          refused = 1'b0;
          foreach (slot_used[i])
            if (slot_used[i] && slot_bound[i] <= ts) refused = 1'b1;
          if (refused) r.status = iwcts_pkg::ST_REFUSED;
          else if (ts > closed_ts) closed_ts = ts;
          r.result_ts = closed_ts;
        end
        iwcts_pkg::OP_DROP: begin
          s = find_writer(id);
          if (s >= 0) slot_used[s] = 1'b0;
        end
        default: ;
      endcase
      expected_q = {expected_q, r};
    endfunction

    function void check_beat(logic [iwcts_pkg::ST_W-1:0] st, ts_t rts);
      iwcts_pkg::result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result beat with nothing expected: status %0d result_ts 0x%0h",
                   $time, st, rts);
        return;
      end
      want = expected_q.pop_front();
      if (st !== want.status || rts !== want.result_ts) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mismatch: status exp %0d got %0d, result_ts exp 0x%0h got 0x%0h",
                   $time, want.status, st, want.result_ts, rts);
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  op_t                         operation = iwcts_pkg::OP_REGISTER;
  id_t                         txn_id = '0;
  ts_t                         timestamp = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [iwcts_pkg::ST_W-1:0]  status;
  ts_t                         result_ts;

  closed_ts_scoreboard sb;
  id_t id_pool[ID_POOL];
  int  sent_beats = 0;
  int  idle_cycles = 0;

  inflight_writer_closed_ts_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .txn_id    (txn_id),
    .timestamp (timestamp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .result_ts (result_ts)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one request beat after a random gap and holds it until accepted.
  task automatic send_beat(op_t op, id_t id, ts_t ts);
    int gap;
    gap = (sent_beats % 128 < 32) ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    txn_id <= id;
    timestamp <= ts;
    do @(posedge clk); while (in_stall);
    sb.note_beat(op, id, ts);
    sent_beats++;
  endtask

  // Most requests stay close to the current closed timestamp or to the lowest
  // stored bound, so that raises, refusals and full-table cases keep coming.
  task automatic random_beat();
    int          pick;
    int          used_q[$];
    op_t         op;
    id_t         id;
    logic [63:0] ts;
    logic [63:0] near_ts;
    ts_t         lowest;
    pick = $urandom_range(0, 99);
    op = (pick < 40) ? iwcts_pkg::OP_REGISTER : (pick < 70) ? iwcts_pkg::OP_ADVERTISE :
         (pick < 95) ? iwcts_pkg::OP_DROP : OP_NONE;
    id = id_pool[$urandom_range(0, ID_POOL - 1)];
    if ($urandom_range(0, 19) == 0) id = $urandom;
    ts = {2'b00, ts_t'({$urandom, $urandom})};
    near_ts = sb.closed_ts + $urandom_range(0, 60);
    near_ts = (near_ts > 20) ? near_ts - 20 : 64'd0;
    if (near_ts > iwcts_pkg::TS_MAX) near_ts = iwcts_pkg::TS_MAX;
    lowest = iwcts_pkg::TS_MAX;
    foreach (sb.slot_used[i])
      if (sb.slot_used[i]) begin
        used_q = {used_q, i};
        if (sb.slot_bound[i] < lowest) lowest = sb.slot_bound[i];
      end
    case (op)
      iwcts_pkg::OP_REGISTER:
        if ($urandom_range(0, 9) != 0) ts = near_ts;
      iwcts_pkg::OP_ADVERTISE: begin
        ts = near_ts;
        if (used_q.size() > 0)
          case ($urandom_range(0, 2))
            0: ts = lowest - 1;
            1: ts = lowest;
            default: ;
          endcase
      end
      iwcts_pkg::OP_DROP:
        if (used_q.size() > 0 && $urandom_range(0, 9) < 7)
          id = sb.slot_txn[used_q[$urandom_range(0, used_q.size() - 1)]];
      default: ;
    endcase
    send_beat(op, id, ts_t'(ts));
  endtask

  // Result checking and the handshake watchdog.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_beat(status, result_ts);
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles < IDLE_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stall per beat, burst stretches, and one long hold-off
  // that lets the block fill up and stall its request side.
  initial begin
    int gap;
    int taken;
    taken = 0;
    wait (!rst);
    forever begin
      gap = (taken % 128 >= 96) ? 0 : $urandom_range(0, 15);
      if (taken == 200) gap = LONG_HOLD;
      @(negedge clk);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    id_t late_id;
    sb = new();
    late_id = 32'h5a5a_0001;
    foreach (id_pool[i]) id_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed beats: empty table, raise and keep, refusal edge, full table,
    // lowest free slot reuse, unknown drop and the unused operation code.
    send_beat(iwcts_pkg::OP_ADVERTISE, '0, '0);
    send_beat(iwcts_pkg::OP_REGISTER, '0, '0);
    send_beat(iwcts_pkg::OP_REGISTER, '0, '0);
    send_beat(iwcts_pkg::OP_REGISTER, '0, ts_t'(100));
    send_beat(iwcts_pkg::OP_ADVERTISE, '0, ts_t'(100));
    send_beat(iwcts_pkg::OP_ADVERTISE, '0, ts_t'(99));
    send_beat(iwcts_pkg::OP_REGISTER, '0, ts_t'(5));
    send_beat(iwcts_pkg::OP_REGISTER, '1, iwcts_pkg::TS_MAX);
    for (int i = 1; i <= TABLE_ENTRIES - 2; i++)
      send_beat(iwcts_pkg::OP_REGISTER, id_t'(i), ts_t'(200 + i));
    send_beat(iwcts_pkg::OP_REGISTER, id_t'(TABLE_ENTRIES), ts_t'(300));
    send_beat(iwcts_pkg::OP_DROP, id_t'(32'h0000_beef), '0);
    send_beat(OP_NONE, '1, iwcts_pkg::TS_MAX);
    send_beat(iwcts_pkg::OP_DROP, '0, '0);
    send_beat(iwcts_pkg::OP_REGISTER, id_t'(TABLE_ENTRIES), ts_t'(300));
    send_beat(iwcts_pkg::OP_DROP, '1, '0);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // Halfway through, let every outstanding result come back first.
      if (n == RANDOM_BEATS / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
      end
      random_beat();
    end

    // Empty the table, then drive the closed timestamp to the top of range,
    // first without and then with saturation of the register floor.
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (sb.slot_used[i]) send_beat(iwcts_pkg::OP_DROP, sb.slot_txn[i], '0);
    send_beat(iwcts_pkg::OP_ADVERTISE, '0, iwcts_pkg::TS_MAX - 1'b1);
    send_beat(iwcts_pkg::OP_REGISTER, late_id, '0);
    send_beat(iwcts_pkg::OP_ADVERTISE, '0, iwcts_pkg::TS_MAX);
    send_beat(iwcts_pkg::OP_DROP, late_id, '0);
    send_beat(iwcts_pkg::OP_ADVERTISE, '0, iwcts_pkg::TS_MAX);
    send_beat(iwcts_pkg::OP_REGISTER, late_id, '0);
    send_beat(iwcts_pkg::OP_REGISTER, late_id, iwcts_pkg::TS_MAX);
    send_beat(iwcts_pkg::OP_ADVERTISE, '0, '0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
